// ===== sv/integer_field_formatter_assert.svh =====
`ifndef INTEGER_FIELD_FORMATTER_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IFF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer field formatter check failed");

// next-cycle implication, checked outside reset
`define IFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer field formatter check failed");

`endif

// ===== sv/iff_pkg.sv =====
package iff_pkg;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
    logic [6:0]         width;
    logic [5:0]         precision;
  } iff_req_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic        last;
    logic [31:0] total_chars;
  } iff_res_t;

  localparam int DIGIT_DEPTH = 11;
  localparam int DIGIT_IDX_W = 4;

  // floor(x / 10) == (x * DEC_RECIP) >> DEC_SHIFT for every 32-bit x
  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int          DEC_SHIFT = 35;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DIVIDE,
    OP_DIGIT,
    OP_SETUP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_MORE,
    COND_LAST
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_LOAD   = 3'd0;
  localparam step_t STEP_DIVIDE = 3'd1;
  localparam step_t STEP_DIGIT  = 3'd2;
  localparam step_t STEP_SETUP  = 3'd3;
  localparam step_t STEP_EMIT   = 3'd4;

  // taken: go to target; not taken: stay if hold, else fall through
  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic more_digits;
    logic emit_last;
  } status_t;

  function automatic ctrl_word_t program_rom(input step_t s);
    ctrl_word_t w;
    unique case (s)
      STEP_LOAD:   w = '{op: OP_LOAD,   cond: COND_ACCEPT, hold: 1'b1, target: STEP_DIVIDE};
      STEP_DIVIDE: w = '{op: OP_DIVIDE, cond: COND_ALWAYS, hold: 1'b0, target: STEP_DIGIT};
      STEP_DIGIT:  w = '{op: OP_DIGIT,  cond: COND_MORE,   hold: 1'b0, target: STEP_DIVIDE};
      STEP_SETUP:  w = '{op: OP_SETUP,  cond: COND_ALWAYS, hold: 1'b0, target: STEP_EMIT};
      STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_LAST,   hold: 1'b1, target: STEP_LOAD};
      default:     w = '{op: OP_LOAD,   cond: COND_ALWAYS, hold: 1'b0, target: STEP_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + 8'(d);
    end else begin
      c = CHAR_A + 8'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// ===== sv/iff_stream_if.sv =====
interface iff_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/iff_datapath.sv =====
module iff_datapath #(
  parameter int MAX_FIELD_CHARS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  iff_pkg::ctrl_word_t cw,
  input  logic                req_fire,
  input  iff_pkg::iff_req_t   req_data,
  input  logic                res_ready,
  output iff_pkg::status_t    status,
  output logic                res_valid,
  output iff_pkg::iff_res_t   res_data
);

  localparam int PW = $clog2(MAX_FIELD_CHARS + 1);
  localparam logic [PW-1:0] MAXW = PW'(MAX_FIELD_CHARS);

  logic        mode;
  logic        neg;
  logic [31:0] mag;
  logic [31:0] quot;
  logic [3:0]  digit_store [iff_pkg::DIGIT_DEPTH];
  logic [iff_pkg::DIGIT_IDX_W-1:0] nd;
  logic [6:0]  width_r;
  logic [5:0]  prec_r;
  logic [PW-1:0] pad;
  logic [PW-1:0] neg_end;
  logic [PW-1:0] zero_end;
  logic [PW-1:0] total;
  logic [PW-1:0] pos;
  logic [31:0] char_total;

  logic [63:0] prod;
  logic [3:0]  digit;
  logic        is_neg_in;
  logic [PW-1:0] w_sat, prec_lim, p_sat, nd_w, neg_w, ndig, body, pad_c;
  logic [PW-1:0] idx_w;
  logic [iff_pkg::DIGIT_IDX_W-1:0] idx;
  logic [3:0]  rd_digit;
  logic [7:0]  char_c;
  logic        last_c;
  logic        emit_go;

  assign prod      = 64'(mag) * 64'(iff_pkg::DEC_RECIP);
  assign is_neg_in = !req_data.mode && req_data.value[31];

  // remainder fits in four bits, so only the low nibble of quot*10 matters
  assign digit = mode ? mag[3:0] : (mag[3:0] - 4'(quot[3:0] * 4'd10));

  assign status.more_digits = (quot != 32'd0) &&
                              (nd < iff_pkg::DIGIT_IDX_W'(iff_pkg::DIGIT_DEPTH - 1));

  // field geometry
  assign neg_w    = PW'(neg);
  assign nd_w     = PW'(nd);
  assign w_sat    = (width_r > 7'(MAX_FIELD_CHARS)) ? MAXW : PW'(width_r);
  assign prec_lim = MAXW - neg_w;
  assign p_sat    = (7'(prec_r) > 7'(prec_lim)) ? prec_lim : PW'(prec_r);
  assign ndig     = (p_sat > nd_w) ? p_sat : nd_w;
  assign body     = ndig + neg_w;
  assign pad_c    = (w_sat > body) ? (w_sat - body) : '0;

  // character at pos
  assign idx_w    = zero_end + nd_w - PW'(1) - pos;
  assign idx      = idx_w[iff_pkg::DIGIT_IDX_W-1:0];
  assign rd_digit = (idx < iff_pkg::DIGIT_IDX_W'(iff_pkg::DIGIT_DEPTH)) ? digit_store[idx] : 4'd0;

  always_comb begin
    priority if (pos < pad) begin
      char_c = iff_pkg::CHAR_SPACE;
    end else if (pos < neg_end) begin
      char_c = iff_pkg::CHAR_MINUS;
    end else if (pos < zero_end) begin
      char_c = iff_pkg::CHAR_ZERO;
    end else begin
      char_c = iff_pkg::digit_char(rd_digit);
    end
  end

  assign last_c           = (pos + PW'(1)) == total;
  assign emit_go          = (cw.op == iff_pkg::OP_EMIT) && (!res_valid || res_ready);
  assign status.emit_last = emit_go && last_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      char_total <= 32'd0;
      nd         <= '0;
      pos        <= '0;
    end else begin
      if (emit_go) begin
        res_valid  <= 1'b1;
        char_total <= char_total + 32'd1;
        pos        <= pos + PW'(1);
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (req_fire) begin
        nd <= '0;
      end else if (cw.op == iff_pkg::OP_DIGIT) begin
        nd <= nd + iff_pkg::DIGIT_IDX_W'(1);
      end
      if (cw.op == iff_pkg::OP_SETUP) begin
        pos <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      mode    <= req_data.mode;
      neg     <= is_neg_in;
      mag     <= is_neg_in ? (32'd0 - $unsigned(req_data.value)) : $unsigned(req_data.value);
      width_r <= req_data.width;
      prec_r  <= req_data.precision;
    end
    unique case (cw.op)
      iff_pkg::OP_DIVIDE: begin
        quot <= mode ? {4'd0, mag[31:4]} : 32'(prod >> iff_pkg::DEC_SHIFT);
      end
      iff_pkg::OP_DIGIT: begin
        digit_store[nd] <= digit;
        mag             <= quot;
      end
      iff_pkg::OP_SETUP: begin
        pad      <= pad_c;
        neg_end  <= pad_c + neg_w;
        zero_end <= pad_c + neg_w + ndig - nd_w;
        total    <= pad_c + body;
      end
      iff_pkg::OP_LOAD, iff_pkg::OP_EMIT: begin
      end
      default: begin
      end
    endcase
    if (emit_go) begin
      res_data.char_out    <= char_c;
      res_data.last        <= last_c;
      res_data.total_chars <= char_total + 32'd1;
    end
  end

endmodule

// ===== sv/integer_field_formatter.sv =====
// integer field formatter: printf-style %d / %x conversion of one 32-bit value
//
// req: one transaction per field: mode (0 signed decimal, 1 lowercase hex of the
//   32-bit pattern), value, minimum width, precision (0 means none)
// res: one transaction per ASCII character: char_out, last on the final
//   character, total_chars counting every character since reset (wraps)
//
// a small control program steps a shared datapath: a load step takes the request,
// each digit takes a divide step (multiply by the reciprocal of ten, or shift by
// four) and a digit step that writes it, then a setup step, then one character per
// cycle while the receiver takes them. D, the digit count of a field, is at most
// 10 decimal or 8 hex
//
// req.ready is high only while the sequencer waits for a request; it may rise while
// the last character of the previous field still sits in the output register.
// when the receiver stalls, the output register holds and emission waits.
// reset clears the sequencer, the output valid flag and the character total.
module integer_field_formatter #(
  parameter int MAX_FIELD_CHARS = 64
) (
  input logic         clk,
  input logic         rst,
  iff_stream_if.sink   req,
  iff_stream_if.source res
);

  iff_pkg::step_t      step;
  iff_pkg::step_t      step_next;
  iff_pkg::ctrl_word_t cw;
  iff_pkg::status_t    status;
  logic                req_fire;
  logic                taken;

  assign cw        = iff_pkg::program_rom(step);
  assign req.ready = (cw.op == iff_pkg::OP_LOAD);
  assign req_fire  = req.valid && req.ready;

  always_comb begin
    unique case (cw.cond)
      iff_pkg::COND_ALWAYS: taken = 1'b1;
      iff_pkg::COND_ACCEPT: taken = req_fire;
      iff_pkg::COND_MORE:   taken = status.more_digits;
      iff_pkg::COND_LAST:   taken = status.emit_last;
      default:              taken = 1'b0;
    endcase
    if (taken) begin
      step_next = cw.target;
    end else if (cw.hold) begin
      step_next = step;
    end else begin
      step_next = step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= iff_pkg::STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

  iff_datapath #(
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cw       (cw),
    .req_fire (req_fire),
    .req_data (req.data),
    .res_ready(res.ready),
    .status   (status),
    .res_valid(res.valid),
    .res_data (res.data)
  );

endmodule

// ===== sv/iff_checker.sv =====
`include "integer_field_formatter_assert.svh"

module iff_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  res_char,
  input logic        res_last,
  input logic [31:0] res_total
);

  logic [31:0] total_seen;
  logic        res_fire;

  assign res_fire = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_seen <= 32'd0;
    end else if (res_fire) begin
      total_seen <= total_seen + 32'd1;
    end
  end

  // running total counts every delivered character
  `IFF_ASSERT_NOW(a_total_counts, clk, rst, res_fire, res_total == total_seen + 32'd1)

  // a request is not taken while the current field still has characters to come
  `IFF_ASSERT_NOW(a_no_req_mid_field, clk, rst, res_valid && !res_last, !req_ready)

  // after a request, the block is busy converting
  `IFF_ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready)

  // stalled character holds
  `IFF_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
                   res_valid && $stable(res_char) && $stable(res_last) && $stable(res_total))

endmodule

bind integer_field_formatter iff_checker u_iff_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_char (res.data.char_out),
  .res_last (res.data.last),
  .res_total(res.data.total_chars)
);

// ===== test/integer_field_formatter_tb.sv =====
`timescale 1ns / 100ps

module integer_field_formatter_tb;

  localparam int   MAX_CHARS = 64;
  localparam logic MODE_DEC  = 1'b0;
  localparam logic MODE_HEX  = 1'b1;
  localparam int   N_RANDOM  = 286;

  logic clk = 1'b0;
  logic rst;

  iff_stream_if #(.payload_t(iff_pkg::iff_req_t)) req_if ();
  iff_stream_if #(.payload_t(iff_pkg::iff_res_t)) res_if ();

  integer_field_formatter #(
    .MAX_FIELD_CHARS(MAX_CHARS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .res(res_if.source)
  );

  iff_pkg::iff_req_t pending_reqs[$];
  iff_pkg::iff_res_t expected_chars[$];
  logic [31:0] chars_so_far;
  int          n_requests;
  int          accepted_reqs;
  int          mismatches;
  int          req_gap;
  int          res_stall;
  int          stall_draw;
  bit          req_steady;
  bit          res_steady;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // builds the characters of one field and appends them to expected_chars
  function automatic void format_field(input iff_pkg::iff_req_t r);
    logic [3:0]  digs[iff_pkg::DIGIT_DEPTH];
    logic        neg;
    logic [31:0] mag;
    int          nd, sign_len, w, p, ndig, body, pad, total, di, zeros;
    logic [3:0]  d;
    iff_pkg::iff_res_t c;
    neg = (r.mode == MODE_DEC) && r.value[31];
    mag = neg ? (32'd0 - r.value) : r.value;
    nd = 0;
    do begin
      if (r.mode == MODE_HEX) begin
        digs[nd] = mag[3:0];
        mag = mag >> 4;
      end else begin
        digs[nd] = 4'(mag % 32'd10);
        mag = mag / 32'd10;
      end
      nd++;
    end while (mag != 0 && nd < iff_pkg::DIGIT_DEPTH);
    sign_len = neg ? 1 : 0;
    w = (int'(r.width) > MAX_CHARS) ? MAX_CHARS : int'(r.width);
    p = (int'(r.precision) > MAX_CHARS - sign_len) ? MAX_CHARS - sign_len : int'(r.precision);
    ndig = (p > nd) ? p : nd;
    body = sign_len + ndig;
    pad = (w > body) ? w - body : 0;
    total = pad + body;
    zeros = ndig - nd;
    for (int k = 0; k < total; k++) begin
      if (k < pad) begin
        c.char_out = iff_pkg::CHAR_SPACE;
      end else if (k < pad + sign_len) begin
        c.char_out = iff_pkg::CHAR_MINUS;
      end else begin
        di = k - pad - sign_len;
        if (di < zeros) begin
          c.char_out = iff_pkg::CHAR_ZERO;
        end else begin
          d = digs[nd - 1 - (di - zeros)];
          c.char_out = (d < 4'd10) ? iff_pkg::CHAR_ZERO + 8'(d) :
                                     iff_pkg::CHAR_A + 8'(d - 4'd10);
        end
      end
      chars_so_far = chars_so_far + 32'd1;
      c.last = (k == total - 1);
      c.total_chars = chars_so_far;
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void add_req(input logic m, input logic [31:0] v, input logic [6:0] w,
                                  input logic [5:0] p);
    iff_pkg::iff_req_t r;
    r.mode = m;
    r.value = v;
    r.width = w;
    r.precision = p;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] p10;
    int          n;
    case ($urandom_range(0, 5))
      0: begin
        v = 32'($urandom_range(0, 255));
      end
      1: begin
        v = 32'd0 - 32'($urandom_range(1, 255));
      end
      2, 3: begin
        v = $urandom;
      end
      default: begin
        // around products of powers of ten and sixteen, including pure powers where the digit count changes
        n = $urandom_range(0, 9);
        p10 = 32'd1;
        for (int i = 0; i < n; i++) p10 = ($urandom_range(0, 1) != 0) ? p10 * 10 : p10 << 4;
        v = p10 + 32'($urandom_range(0, 2)) - 32'd1;
        if ($urandom_range(0, 2) == 0) v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      req_gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        format_field(req_if.data);
        accepted_reqs <= accepted_reqs + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_gap <= req_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_if.data <= pending_reqs.pop_front();
          req_if.valid <= 1'b1;
          if ($urandom_range(0, 23) == 0) req_steady = !req_steady;
          req_gap <= req_steady ? 0 : $urandom_range(0, 11);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // character monitor
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      res_stall <= 0;
    end else if (res_if.valid && res_if.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected char", 32'(res_if.data.char_out), 32'd0);
      end else begin
        if (res_if.data.char_out !== expected_chars[0].char_out)
          report_mismatch("char_out", 32'(res_if.data.char_out),
                          32'(expected_chars[0].char_out));
        if (res_if.data.last !== expected_chars[0].last)
          report_mismatch("last", 32'(res_if.data.last), 32'(expected_chars[0].last));
        if (res_if.data.total_chars !== expected_chars[0].total_chars)
          report_mismatch("total_chars", res_if.data.total_chars,
                          expected_chars[0].total_chars);
        void'(expected_chars.pop_front());
      end
      if ($urandom_range(0, 63) == 0) res_steady = !res_steady;
      stall_draw = res_steady ? 0 : $urandom_range(0, 11);
      res_stall <= stall_draw;
      res_if.ready <= (stall_draw == 0);
    end else if (res_stall != 0) begin
      res_stall <= res_stall - 1;
      res_if.ready <= (res_stall == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  initial begin
    #10_000_000;
    $display("integer_field_formatter_tb NOT OK");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
    chars_so_far = '0;
    accepted_reqs = 0;
    mismatches = 0;
    req_steady = 1'b0;
    res_steady = 1'b0;

    // zeros, extremes, digit-count boundaries, saturating width and precision
    add_req(MODE_DEC, 32'd0, 7'd0, 6'd0);
    add_req(MODE_HEX, 32'd0, 7'd0, 6'd0);
    add_req(MODE_HEX, 32'd0, 7'd4, 6'd1);
    add_req(MODE_DEC, 32'h8000_0000, 7'd0, 6'd0);
    add_req(MODE_DEC, 32'h8000_0000, 7'd64, 6'd63);
    add_req(MODE_DEC, 32'h7FFF_FFFF, 7'd0, 6'd0);
    add_req(MODE_HEX, 32'h8000_0000, 7'd0, 6'd0);
    add_req(MODE_HEX, 32'hFFFF_FFFF, 7'd3, 6'd0);
    add_req(MODE_DEC, 32'hFFFF_FFFF, 7'd5, 6'd0);
    add_req(MODE_HEX, 32'hDEAD_BEEF, 7'd12, 6'd10);
    add_req(MODE_DEC, 32'd123, 7'd127, 6'd0);
    add_req(MODE_DEC, 32'd42, 7'd65, 6'd3);
    add_req(MODE_DEC, 32'hFFFF_FFF9, 7'd0, 6'd63);
    add_req(MODE_HEX, 32'h00AB_CDEF, 7'd64, 6'd63);
    add_req(MODE_DEC, 32'd5, 7'd127, 6'd63);
    add_req(MODE_DEC, 32'd1, 7'd1, 6'd1);
    add_req(MODE_DEC, 32'd9, 7'd0, 6'd0);
    add_req(MODE_DEC, 32'd10, 7'd0, 6'd0);
    add_req(MODE_DEC, 32'd999_999_999, 7'd10, 6'd0);
    add_req(MODE_DEC, 32'd1_000_000_000, 7'd0, 6'd11);
    add_req(MODE_DEC, 32'hC465_3600, 7'd0, 6'd0);
    add_req(MODE_HEX, 32'd15, 7'd0, 6'd0);
    add_req(MODE_HEX, 32'd16, 7'd0, 6'd2);
    add_req(MODE_HEX, 32'h1000_0000, 7'd9, 6'd0);

    for (int i = 0; i < N_RANDOM; i++) begin
      add_req(1'($urandom_range(0, 1)), pick_value(),
              ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 20)) :
              ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 127)) :
                                           7'($urandom_range(60, 127)),
              ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 12)) :
                                           6'($urandom_range(0, 63)));
    end
    n_requests = pending_reqs.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted_reqs < n_requests || expected_chars.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch("chars never seen", 32'(expected_chars.size()), 32'd0);

    if (mismatches == 0) begin
      $display("integer_field_formatter_tb OK");
    end else begin
      $display("integer_field_formatter_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/iff_pkg.sv
sv/iff_stream_if.sv
sv/iff_datapath.sv
sv/integer_field_formatter.sv
sv/iff_checker.sv
test/integer_field_formatter_tb.sv
